@@ rtl/grg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package grg_pkg;

  typedef struct packed {
    logic [15:0] stop_red;
    logic [15:0] stop_green;
    logic [15:0] stop_blue;
    logic [15:0] stop_alpha;
    logic [16:0] stop_position;
    logic        first_stop;
  } stop_t;

  typedef struct packed {
    logic [5:0]  texel_index;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic        end_of_segment;
  } texel_t;

  localparam logic       CFG_RESOLUTION    = 1'b0;
  localparam logic       CFG_OUTPUT_FORMAT = 1'b1;
  localparam logic [6:0] RES_RESET         = 7'd64;
  localparam logic       FMT_HALF          = 1'b1;
  localparam logic [15:0] HALF_ONE         = 16'h3C00;
  localparam logic [3:0] DIV_LAST          = 4'd15;

endpackage
`default_nettype wire

@@ rtl/gradient_ramp_generator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake               payload
// in       in   in_valid / in_ready     in_data (stop_t)
// out      out  out_valid / out_ready   out_data (texel_t)
// cfg      in   cfg_we                  cfg_index, cfg_data
//
// a first stop is taken in the idle state; any other stop passes a setup state for the index
// multiply and compare, then these states plus the output wait for each texel
// emitted: one product, 16 steps of the per-channel restoring dividers, sum, encode
// in_ready is high only while idle; a stalled output beat holds the sequencer
// synchronous active-high reset clears state, colour history, prev_index, format and out_valid; resolution goes to 64
module gradient_ramp_generator_core
  import grg_pkg::*;
#(
  parameter int MAX_TEXELS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire stop_t      in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output texel_t          out_data,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [6:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_MUL, S_DIV, S_SUM, S_ENC, S_OUT
  } state_t;

  state_t      state;
  logic [6:0]  resolution;
  logic        output_format;
  logic [15:0] prev_color [4];
  logic [5:0]  prev_index;
  logic [15:0] c1 [4];
  logic [16:0] pos;
  logic [5:0]  next_index;
  logic [5:0]  span;
  logic [5:0]  cur;
  logic [3:0]  step;
  logic        neg [4];
  logic [5:0]  rem [4];
  logic [15:0] dvd [4];
  logic [15:0] vval [4];

  logic [6:0]  res_eff;
  logic [23:0] pos_prod;
  logic [7:0]  idx_raw;
  logic [5:0]  idx_sat;
  logic [5:0]  k;
  logic [15:0] enc [4];

  function automatic logic [15:0] enc8(input logic [15:0] c);
    logic [16:0] x;
    logic [24:0] p;
    logic [8:0]  q0;
    logic [17:0] r;
    x  = {1'b0, c} + 17'd128;
    p  = {x, 8'b0} - {8'b0, x};
    q0 = p[24:16];
    r  = {1'b0, x} - ({q0, 8'b0} + {8'b0, q0}) ;
    if (r >= 18'd257) q0 = q0 + 9'd1;
    return {8'b0, q0[7:0]};
  endfunction

  function automatic logic [15:0] enc_half(input logic [15:0] c);
    logic [4:0]  bl;
    logic [4:0]  s;
    logic [16:0] norm;
    logic [10:0] q;
    logic [16:0] r;
    bl = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (c[i]) bl = 5'(i + 1);
    end
    s    = 5'd17 - bl;
    norm = {1'b0, c} << s;
    q    = norm[16:6];
    r    = {norm[5:0], 11'b0} >> 1;
    r    = r + {6'b0, q};
    if (r >= 17'd65535) q = q + 11'd1;
    if (c == 16'hFFFF) return HALF_ONE;
    if (c < 16'd4) return 16'd0;
    return {1'b0, 5'd15 - s, q[9:0]};
  endfunction

  assign in_ready = (state == S_IDLE);

  always_comb begin
    if (resolution < 7'd2) res_eff = 7'd2;
    else if (resolution > 7'(MAX_TEXELS)) res_eff = 7'(MAX_TEXELS);
    else res_eff = resolution;
    pos_prod = {7'b0, pos} * {17'b0, res_eff};
    idx_raw  = pos_prod[23:16];
    if (idx_raw > {1'b0, res_eff} - 8'd1) idx_sat = 6'(res_eff - 7'd1);
    else idx_sat = idx_raw[5:0];
    k = cur - prev_index;
    for (int ch = 0; ch < 4; ch++) begin
      enc[ch] = (output_format == FMT_HALF) ? enc_half(vval[ch]) : enc8(vval[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      resolution    <= RES_RESET;
      output_format <= 1'b0;
      prev_index    <= 6'd0;
      out_valid     <= 1'b0;
      for (int ch = 0; ch < 4; ch++) prev_color[ch] <= 16'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RESOLUTION:    resolution <= cfg_data;
          CFG_OUTPUT_FORMAT: output_format <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.first_stop) begin
              prev_color[0] <= in_data.stop_red;
              prev_color[1] <= in_data.stop_green;
              prev_color[2] <= in_data.stop_blue;
              prev_color[3] <= in_data.stop_alpha;
              prev_index    <= 6'd0;
            end else begin
              c1[0] <= in_data.stop_red;
              c1[1] <= in_data.stop_green;
              c1[2] <= in_data.stop_blue;
              c1[3] <= in_data.stop_alpha;
              pos   <= in_data.stop_position;
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          next_index <= idx_sat;
          if (idx_sat > prev_index) begin
            span  <= idx_sat - prev_index;
            cur   <= prev_index;
            state <= S_MUL;
          end else begin
            for (int ch = 0; ch < 4; ch++) prev_color[ch] <= c1[ch];
            prev_index <= idx_sat;
            state      <= S_IDLE;
          end
        end
        S_MUL: begin
          for (int ch = 0; ch < 4; ch++) begin
            logic [15:0] mag;
            logic [21:0] prod;
            mag  = (c1[ch] < prev_color[ch]) ? prev_color[ch] - c1[ch]
                                             : c1[ch] - prev_color[ch];
            prod = {6'b0, mag} * {16'b0, k};
            neg[ch] <= (c1[ch] < prev_color[ch]);
            rem[ch] <= prod[21:16];
            dvd[ch] <= prod[15:0];
          end
          step  <= 4'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          for (int ch = 0; ch < 4; ch++) begin
            logic [6:0] t;
            t = {rem[ch], dvd[ch][15]};
            if (t >= {1'b0, span}) begin
              rem[ch] <= 6'(t - {1'b0, span});
              dvd[ch] <= {dvd[ch][14:0], 1'b1};
            end else begin
              rem[ch] <= t[5:0];
              dvd[ch] <= {dvd[ch][14:0], 1'b0};
            end
          end
          step <= step + 4'd1;
          if (step == DIV_LAST) state <= S_SUM;
        end
        S_SUM: begin
          for (int ch = 0; ch < 4; ch++) begin
            vval[ch] <= neg[ch] ? prev_color[ch] - dvd[ch] : prev_color[ch] + dvd[ch];
          end
          state <= S_ENC;
        end
        S_ENC: begin
          out_data.texel_index    <= cur;
          out_data.out_red        <= enc[0];
          out_data.out_green      <= enc[1];
          out_data.out_blue       <= enc[2];
          out_data.out_alpha      <= enc[3];
          out_data.end_of_segment <= (cur == next_index);
          out_valid               <= 1'b1;
          state                   <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (cur == next_index) begin
              for (int ch = 0; ch < 4; ch++) prev_color[ch] <= c1[ch];
              prev_index <= next_index;
              state      <= S_IDLE;
            end else begin
              cur   <= cur + 6'd1;
              state <= S_MUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/grg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module grg_checker
  import grg_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire stop_t      in_data,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire texel_t     out_data
);

  // no input beat taken while a texel waits
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("in_ready with out_valid");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled beat changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.first_stop |=> !in_ready)
    else $error("ready right after a stop");

  a_more: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.end_of_segment |=> !in_ready)
    else $error("ready before segment end");

endmodule

bind gradient_ramp_generator_core grg_checker u_grg_checker (.*);
`default_nettype wire
